// ----- rtl/core/double_hash_key_dictionary_unit_defines.svh -----
// Assertion macros for the DNA word dictionary block.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef DOUBLE_HASH_KEY_DICTIONARY_UNIT_DEFINES_SVH
`define DOUBLE_HASH_KEY_DICTIONARY_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define DHK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define DHK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dhk_pkg.sv -----
// Shared constants, types and helper functions of the DNA word dictionary.
// Depends on nothing; the interfaces, the hash unit, the top level and the testbench import it.
package dhk_pkg;

    localparam int TABLE_SIZE   = 1021;
    localparam int MAX_LETTERS  = 12;

    localparam int LETTERS_W    = 24;
    localparam int LEN_W        = 4;
    localparam int KEY_W        = 28;
    localparam int NUM_LETTERS  = LETTERS_W / 2;
    localparam int HALF_LETTERS = NUM_LETTERS / 2;

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int REM_W  = $clog2(2 * TABLE_SIZE);

    // Request operation codes.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    // Reply status codes.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    function automatic int pow5(input int n);
        int acc;
        acc = 1;
        for (int k = 0; k < n; k++) begin
            acc = acc * 5;
        end
        return acc;
    endfunction

    localparam int POW5_HALF = pow5(HALF_LETTERS);
    localparam int HALF_W    = $clog2(POW5_HALF);

    // Reciprocals for the two constant remainders; the quotient estimate is
    // at most one below the true quotient for any key of KEY_W bits.
    localparam logic [KEY_W-1:0] RECIP_HOME = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);
    localparam logic [KEY_W-1:0] RECIP_STEP = KEY_W'((64'd1 << KEY_W) / (TABLE_SIZE - 1));

    typedef struct packed {
        logic              done;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] step;
    } t_hash_res;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/dhk_if.sv -----
// Request and reply channel interfaces of the DNA word dictionary.
// Depends on dhk_pkg for the payload widths.
interface dhk_req_if import dhk_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [LETTERS_W-1:0] letters;
    logic [LEN_W-1:0]     length;

    modport source (output valid, output func, output letters, output length, input ready);
    modport sink   (input valid, input func, input letters, input length, output ready);
endinterface

interface dhk_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic status;

    modport source (output valid, output found, output status, input ready);
    modport sink   (input valid, input found, input status, output ready);
endinterface

// ----- rtl/core/dhk_hash_unit.sv -----
// Four-stage key and hash pipeline: word to base-5 key, home slot and step.
// Depends on dhk_pkg.
module dhk_hash_unit import dhk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [LETTERS_W-1:0] i_letters,
    input  logic [LEN_W-1:0]     i_length,
    output t_hash_res            o_res
);

    logic [LEN_W-1:0]   w_len_sat;
    logic [HALF_W-1:0]  n_lo, n_hi;
    logic [HALF_W-1:0]  r_lo, r_hi;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_q_home, r_q_step;
    logic [REM_W-1:0]   r_rem_home, r_rem_step;
    logic [3:0]         r_stage_v;
    logic [2*KEY_W-1:0] w_prod_home, w_prod_step;
    logic [REM_W-1:0]   w_fix_home, w_fix_step;

    // Stage 0: two half sums of weighted letter digits.
    always_comb begin
        w_len_sat = (i_length > LEN_W'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS) : i_length;
        n_lo = '0;
        n_hi = '0;
        for (int i = 0; i < HALF_LETTERS; i++) begin
            if (i < int'(w_len_sat)) begin
                n_lo = n_lo + HALF_W'((int'(i_letters[2*i +: 2]) + 1) * pow5(i));
            end
            if ((i + HALF_LETTERS) < int'(w_len_sat)) begin
                n_hi = n_hi + HALF_W'(
                    (int'(i_letters[2*(i + HALF_LETTERS) +: 2]) + 1) * pow5(i));
            end
        end
    end

    assign w_prod_home = (2*KEY_W)'(r_key) * (2*KEY_W)'(RECIP_HOME);
    assign w_prod_step = (2*KEY_W)'(r_key) * (2*KEY_W)'(RECIP_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_v <= '0;
        end else begin
            r_stage_v <= {r_stage_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (r_stage_v[0]) begin
            r_key <= KEY_W'(r_lo) + KEY_W'(KEY_W'(r_hi) * KEY_W'(POW5_HALF));
        end
        if (r_stage_v[1]) begin
            r_q_home <= w_prod_home[2*KEY_W-1:KEY_W];
            r_q_step <= w_prod_step[2*KEY_W-1:KEY_W];
        end
        if (r_stage_v[2]) begin
            r_rem_home <= REM_W'(r_key - KEY_W'(r_q_home * KEY_W'(TABLE_SIZE)));
            r_rem_step <= REM_W'(r_key - KEY_W'(r_q_step * KEY_W'(TABLE_SIZE - 1)));
        end
    end

    // The quotient estimate can be one short, so one subtraction finishes it.
    assign w_fix_home = (r_rem_home >= REM_W'(TABLE_SIZE))
                      ? r_rem_home - REM_W'(TABLE_SIZE) : r_rem_home;
    assign w_fix_step = (r_rem_step >= REM_W'(TABLE_SIZE - 1))
                      ? r_rem_step - REM_W'(TABLE_SIZE - 1) : r_rem_step;

    assign o_res.done = r_stage_v[3];
    assign o_res.key  = r_key;
    assign o_res.home = SLOT_W'(w_fix_home);
    assign o_res.step = SLOT_W'(w_fix_step) + SLOT_W'(1);

endmodule

// ----- rtl/core/double_hash_key_dictionary_unit.sv -----
// Top level of the DNA word dictionary: open-addressing table with double hashing.
// Depends on dhk_pkg, dhk_if, dhk_hash_unit and the assertion macro header.
//
//   channel | direction | payload                         | accepted when
//   i_req   | in        | func, letters[23:0], length[3:0] | valid && ready
//   o_rsp   | out       | found, status                    | valid && ready
//
// One request is worked at a time. Key and hash are formed in the hash
// pipeline; each probe then reads the single-port slot memory, then checks
// the slot and possibly writes it. A request probes until it settles, or
// through all 1021 slots when the table is full. After reset a clearing
// pass writes zero to all 1021 slots, one per cycle, and no request is
// accepted until it ends. The reply register lets the next request be
// accepted while a reply still waits to be taken.
`include "double_hash_key_dictionary_unit_defines.svh"

module double_hash_key_dictionary_unit import dhk_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dhk_req_if.sink   i_req,
    dhk_rsp_if.source o_rsp
);

    // Slot memory: one port, registered read data, zero means empty.
    logic [KEY_W-1:0] r_mem [TABLE_SIZE];
    logic [KEY_W-1:0] r_rdata;
    logic [SLOT_W-1:0] w_addr;
    logic              w_we;
    logic [KEY_W-1:0]  w_wdata;

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_func, n_func;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_probe, n_probe;
    logic              r_found, n_found;
    logic              r_status, n_status;
    logic              r_rsp_valid, n_rsp_valid;
    logic              r_rsp_found, n_rsp_found;
    logic              r_rsp_status, n_rsp_status;

    logic              w_accept;
    logic              w_rsp_free;
    logic              w_held_empty;
    logic              w_held_match;
    logic [CNT_W-1:0]  w_probe_inc;
    logic [SLOT_W:0]   w_slot_sum;
    logic [SLOT_W-1:0] w_slot_next;
    t_hash_res         w_hash;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_rsp_free  = !r_rsp_valid || o_rsp.ready;

    dhk_hash_unit u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_letters (i_req.letters),
        .i_length  (i_req.length),
        .o_res     (w_hash)
    );

    assign w_held_empty = (r_rdata == '0);
    assign w_held_match = (r_rdata == r_key);
    assign w_probe_inc  = r_probe + CNT_W'(1);
    assign w_slot_sum   = (SLOT_W+1)'(r_slot) + (SLOT_W+1)'(r_step);
    assign w_slot_next  = (w_slot_sum >= (SLOT_W+1)'(TABLE_SIZE))
                        ? SLOT_W'(w_slot_sum - (SLOT_W+1)'(TABLE_SIZE))
                        : SLOT_W'(w_slot_sum);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SLOT_W'(TABLE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (w_hash.done) begin
                    // A zero key comes only from an empty word, which is answered
                    // without touching the table.
                    n_state = (w_hash.key == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_held_empty || (r_func == FUNC_FIND && w_held_match)
                        || w_probe_inc == CNT_W'(TABLE_SIZE)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (w_rsp_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_func       = r_func;
        n_key        = r_key;
        n_slot       = r_slot;
        n_step       = r_step;
        n_probe      = r_probe;
        n_found      = r_found;
        n_status     = r_status;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_rsp_found  = r_rsp_found;
        n_rsp_status = r_rsp_status;
        w_addr       = r_slot;
        w_we         = 1'b0;
        w_wdata      = r_key;
        case (r_state)
            ST_CLEAR: begin
                w_addr     = r_clr_addr;
                w_we       = 1'b1;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + SLOT_W'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_func = i_req.func;
                end
            end
            ST_HASH: begin
                n_key    = w_hash.key;
                n_slot   = w_hash.home;
                n_step   = w_hash.step;
                n_probe  = '0;
                n_found  = 1'b0;
                n_status = STATUS_DONE;
            end
            ST_CHECK: begin
                if (r_func == FUNC_INSERT && w_held_empty) begin
                    w_we     = 1'b1;
                    n_found  = 1'b1;
                    n_status = STATUS_DONE;
                end else if (r_func == FUNC_FIND && w_held_match) begin
                    n_found  = 1'b1;
                    n_status = STATUS_DONE;
                end else if (w_held_empty) begin
                    n_found  = 1'b0;
                    n_status = STATUS_DONE;
                end else if (w_probe_inc == CNT_W'(TABLE_SIZE)) begin
                    n_found  = 1'b0;
                    n_status = STATUS_FULL;
                end else begin
                    n_probe = w_probe_inc;
                    n_slot  = w_slot_next;
                end
            end
            ST_DONE: begin
                if (w_rsp_free) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_found  = r_found;
                    n_rsp_status = r_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_step       <= n_step;
        r_probe      <= n_probe;
        r_found      <= n_found;
        r_status     <= n_status;
        r_rsp_found  <= n_rsp_found;
        r_rsp_status <= n_rsp_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    assign o_rsp.valid  = r_rsp_valid;
    assign o_rsp.found  = r_rsp_found;
    assign o_rsp.status = r_rsp_status;

    // The table is written only by the clearing pass or by an insert that met
    // an empty slot.
    `DHK_ASSERT_SAME(a_write_source, w_we,
        (r_state == ST_CLEAR) || (r_state == ST_CHECK && r_func == FUNC_INSERT && w_held_empty),
        "slot memory written outside clear or insert")
    // The probe counter never runs past the table size.
    `DHK_ASSERT_SAME(a_probe_bound, r_state == ST_CHECK,
        r_probe < CNT_W'(TABLE_SIZE), "probe count beyond table size")
    // A stored or found word is never reported together with a full table.
    `DHK_ASSERT_SAME(a_reply_code, o_rsp.valid && o_rsp.found,
        o_rsp.status == STATUS_DONE, "found reply carries full status")
    // The hash pipeline delivers only while the sequencer waits for it.
    `DHK_ASSERT_SAME(a_hash_timing, w_hash.done,
        r_state == ST_HASH, "hash result outside hash wait")

endmodule

// ----- dv/tb_double_hash_key_dictionary_unit.sv -----
// Self-checking testbench for double_hash_key_dictionary_unit (DNA word dictionary).
// Depends on dhk_pkg and the dhk_req_if / dhk_rsp_if channel interfaces of the RTL.
// A shadow hash table predicts found/status for every accepted request in order.
module tb_double_hash_key_dictionary_unit;
    import dhk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Long receiver hold-off, in cycles, used by the backpressure test.
    localparam int HOLD_CYCLES = 400;
    // The slowest request probes every slot, each with a read and then a check.
    localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 16;
    // Mismatch lines printed before the report task only counts.
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic found;
        logic status;
    } t_dict_reply;

    typedef struct {
        logic                 func;
        logic [LETTERS_W-1:0] letters;
        logic [LEN_W-1:0]     len;
        t_dict_reply          want;
        int                   seq;
    } t_dict_request;

    typedef struct {
        logic [LETTERS_W-1:0] letters;
        logic [LEN_W-1:0]     len;
    } t_dna_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dhk_req_if req_if ();
    dhk_rsp_if rsp_if ();

    double_hash_key_dictionary_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the slot memory; zero marks an empty slot.
    logic [KEY_W-1:0] dict_slots [TABLE_SIZE];
    int unsigned      slots_used;
    // Every word the shadow table actually stored, for later finds and duplicates.
    t_dna_word        stored_words [$];
    // Requests accepted by the block whose replies have not been taken yet.
    t_dict_request    pending_replies [$];

    int req_idle_pct;
    int rsp_idle_pct;
    int error_count;
    int req_seq;
    int insert_count;
    int find_count;
    int reply_count;
    int full_reply_count;

    // The receiver hold-off runs in its own process so the sender keeps pushing.
    event hold_go;
    logic hold_active = 1'b0;

    // Base-5 key: each letter becomes a digit 1..4, the first letter is the
    // least significant digit, and lengths past the maximum are clipped.
    function automatic logic [KEY_W-1:0] dna_key(input logic [LETTERS_W-1:0] letters,
                                                 input logic [LEN_W-1:0] len);
        int unsigned n;
        int unsigned sum;
        int unsigned weight;
        int          i;
        n      = (len > MAX_LETTERS) ? MAX_LETTERS : len;
        sum    = 0;
        weight = 1;
        for (i = 0; i < n; i++) begin
            sum    = sum + weight * (letters[2*i +: 2] + 1);
            weight = weight * 5;
        end
        return sum[KEY_W-1:0];
    endfunction

    // Applies one request to the shadow table and returns the reply it must cause.
    function automatic t_dict_reply dict_apply(input logic func,
                                               input logic [LETTERS_W-1:0] letters,
                                               input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] key;
        int unsigned      slot;
        int unsigned      stride;
        int unsigned      probe;
        logic             settled;
        t_dict_reply      r;
        key      = dna_key(letters, len);
        r.found  = 1'b0;
        r.status = STATUS_DONE;
        // An empty word forms key zero, which can never be stored or found.
        if (key != '0) begin
            r.status = STATUS_FULL;
            slot     = key % TABLE_SIZE;
            stride   = 1 + key % (TABLE_SIZE - 1);
            settled  = 1'b0;
            probe    = 0;
            // Running out of probes leaves status at FULL.
            while (!settled && probe < TABLE_SIZE) begin
                if (func == FUNC_INSERT) begin
                    if (dict_slots[slot] == '0) begin
                        dict_slots[slot] = key;
                        slots_used++;
                        r.found  = 1'b1;
                        r.status = STATUS_DONE;
                        settled  = 1'b1;
                    end
                end else if (dict_slots[slot] == key) begin
                    r.found  = 1'b1;
                    r.status = STATUS_DONE;
                    settled  = 1'b1;
                end else if (dict_slots[slot] == '0) begin
                    r.status = STATUS_DONE;
                    settled  = 1'b1;
                end
                slot = slot + stride;
                if (slot >= TABLE_SIZE) begin
                    slot = slot - TABLE_SIZE;
                end
                probe++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    // Compares one reply taken from the block with the oldest outstanding request.
    task automatic check_reply(input logic found, input logic status);
        t_dict_request head;
        string         tag;
        reply_count++;
        if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply found=%0b status=%0b with no request outstanding",
                                      found, status));
        end else begin
            head = pending_replies.pop_front();
            tag  = $sformatf("request %0d func=%0b letters=%06h len=%0d",
                             head.seq, head.func, head.letters, head.len);
            if (found !== head.want.found) begin
                report_mismatch({tag, $sformatf(": found %0b, want %0b",
                                                found, head.want.found)});
            end
            if (status !== head.want.status) begin
                report_mismatch({tag, $sformatf(": status %0b, want %0b",
                                                status, head.want.status)});
            end
        end
    endtask

    // Reply side: take and check replies, and randomly withhold ready. The
    // long hold-off overrides the random choice while it runs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                check_reply(rsp_if.found, rsp_if.status);
            end
            rsp_if.ready <= !hold_active && ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    initial begin
        forever begin
            @(hold_go);
            @(posedge i_clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // Offers one request and holds it until the block takes it. Valid stays
    // high across back-to-back requests; it is lowered only for an idle gap.
    task automatic send_request(input logic func, input logic [LETTERS_W-1:0] letters,
                                input logic [LEN_W-1:0] len);
        t_dict_request req;
        t_dna_word     word;
        int            gap;
        req_if.valid   <= 1'b1;
        req_if.func    <= func;
        req_if.letters <= letters;
        req_if.length  <= len;
        do @(posedge i_clk); while (!req_if.ready);
        req.func    = func;
        req.letters = letters;
        req.len     = len;
        req.seq     = req_seq++;
        req.want    = dict_apply(func, letters, len);
        pending_replies.push_back(req);
        if (func == FUNC_INSERT) begin
            insert_count++;
            if (req.want.found) begin
                word.letters = letters;
                word.len     = len;
                stored_words.push_back(word);
            end
        end else begin
            find_count++;
        end
        if (req.want.status == STATUS_FULL) begin
            full_reply_count++;
        end
        gap = 0;
        while (gap < 30 && $urandom_range(99) < req_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drops valid so that no stale request can be taken again.
    task automatic stop_requests();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly long words so keys spread over the table; short ones collide often.
    function automatic logic [LEN_W-1:0] pick_length();
        if ($urandom_range(99) < 20) begin
            return LEN_W'($urandom_range(1, 5));
        end
        return LEN_W'($urandom_range(6, MAX_LETTERS));
    endfunction

    function automatic logic [LETTERS_W-1:0] pick_letters();
        return LETTERS_W'($urandom());
    endfunction

    // Re-sends a stored word with fresh junk in the letters past its length,
    // and sometimes an over-long length that clips to the same word.
    task automatic send_known_word(input logic func);
        t_dna_word            word;
        logic [LETTERS_W-1:0] mask;
        logic [LETTERS_W-1:0] letters;
        logic [LEN_W-1:0]     len;
        int                   n;
        word    = stored_words[$urandom_range(stored_words.size() - 1)];
        n       = (word.len > MAX_LETTERS) ? MAX_LETTERS : word.len;
        mask    = (n >= NUM_LETTERS) ? '1 : LETTERS_W'((1 << (2 * n)) - 1);
        letters = (word.letters & mask) | (pick_letters() & ~mask);
        len     = word.len;
        if (n == MAX_LETTERS && $urandom_range(1) == 1) begin
            len = LEN_W'($urandom_range(MAX_LETTERS, 15));
        end
        send_request(func, letters, len);
    endtask

    // Edge cases: empty table, empty word, single letters, the longest word,
    // clipped lengths, junk above the length and duplicate inserts.
    task automatic test_directed_words();
        req_idle_pct = 30;
        rsp_idle_pct = 30;
        send_request(FUNC_FIND,   24'h000001, 4'd1);   // nothing stored yet
        send_request(FUNC_INSERT, 24'hFFFFFF, 4'd0);   // empty word is ignored
        send_request(FUNC_FIND,   24'h000000, 4'd0);
        send_request(FUNC_INSERT, 24'h000000, 4'd1);   // A
        send_request(FUNC_INSERT, 24'h000001, 4'd1);   // C
        send_request(FUNC_INSERT, 24'h000002, 4'd1);   // G
        send_request(FUNC_INSERT, 24'h000003, 4'd1);   // T
        send_request(FUNC_FIND,   24'hFFFFFC, 4'd1);   // A with junk above it
        send_request(FUNC_INSERT, 24'h000000, 4'd1);   // duplicate takes another slot
        send_request(FUNC_INSERT, 24'hFFFFFF, 4'd12);  // largest key
        send_request(FUNC_INSERT, 24'hFFFFFF, 4'd15);  // clipped to the same word
        send_request(FUNC_FIND,   24'hFFFFFF, 4'd13);
        send_request(FUNC_FIND,   24'hFFFFFF, 4'd14);
        send_request(FUNC_INSERT, 24'h000000, 4'd12);  // twelve A letters
        send_request(FUNC_FIND,   24'h000000, 4'd11);  // shorter word is different
        send_request(FUNC_FIND,   24'h000000, 4'd12);
        send_request(FUNC_INSERT, 24'h555555, 4'd12);
        send_request(FUNC_FIND,   24'hAAAAAA, 4'd12);
        send_request(FUNC_FIND,   24'h555555, 4'd12);
        send_request(FUNC_INSERT, 24'h000000, 4'd0);
        stop_requests();
        wait_drained();
    endtask

    // Mixed traffic: new inserts, duplicates, finds of stored words, finds
    // of random words and odd lengths (empty and over-long).
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int count);
        int pick;
        int k;
        req_idle_pct = sender_pct;
        rsp_idle_pct = receiver_pct;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 40 || stored_words.size() == 0) begin
                send_request(FUNC_INSERT, pick_letters(), pick_length());
            end else if (pick < 48) begin
                send_known_word(FUNC_INSERT);
            end else if (pick < 78) begin
                send_known_word(FUNC_FIND);
            end else if (pick < 93) begin
                send_request(FUNC_FIND, pick_letters(), pick_length());
            end else if (pick < 96) begin
                send_request(logic'($urandom_range(1)), pick_letters(), 4'd0);
            end else begin
                send_request(logic'($urandom_range(1)), pick_letters(),
                             LEN_W'($urandom_range(MAX_LETTERS + 1, 15)));
            end
        end
        // The sender waits here until every outstanding reply has come back.
        stop_requests();
        wait_drained();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so
    // the reply register fills and the block has to hold its input off.
    task automatic test_reply_backpressure();
        int k;
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        -> hold_go;
        for (k = 0; k < 16; k++) begin
            if ($urandom_range(1) == 1) begin
                send_known_word(FUNC_FIND);
            end else begin
                send_request(FUNC_INSERT, pick_letters(), pick_length());
            end
        end
        stop_requests();
        wait_drained();
    endtask

    // Inserts until every slot holds a key; late inserts probe long chains.
    task automatic test_fill_to_capacity();
        req_idle_pct = 5;
        rsp_idle_pct = 5;
        while (slots_used < TABLE_SIZE) begin
            send_request(FUNC_INSERT, pick_letters(), pick_length());
        end
        stop_requests();
        wait_drained();
    endtask

    // With no empty slot left, inserts and finds of absent words run out of
    // probes; finds of stored words and empty words still complete.
    task automatic test_full_table();
        req_idle_pct = 20;
        rsp_idle_pct = 20;
        send_request(FUNC_INSERT, pick_letters(), 4'd12);
        send_known_word(FUNC_INSERT);
        send_request(FUNC_FIND, pick_letters(), 4'd12);
        send_request(FUNC_FIND, pick_letters(), 4'd11);
        send_known_word(FUNC_FIND);
        send_known_word(FUNC_FIND);
        send_request(FUNC_INSERT, pick_letters(), 4'd0);
        send_request(FUNC_FIND, pick_letters(), 4'd15);
        stop_requests();
        wait_drained();
    endtask

    initial begin
        foreach (dict_slots[i]) begin
            dict_slots[i] = '0;
        end
        slots_used       = 0;
        req_idle_pct     = 0;
        rsp_idle_pct     = 0;
        error_count      = 0;
        req_seq          = 0;
        insert_count     = 0;
        find_count       = 0;
        reply_count      = 0;
        full_reply_count = 0;
        req_if.valid     = 1'b0;
        req_if.func      = FUNC_INSERT;
        req_if.letters   = '0;
        req_if.length    = '0;

        // Reset once; the block then clears its table before taking requests,
        // which the first handshake simply waits out.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_words();
        test_random_traffic(14, 78, 300);
        test_random_traffic(78, 14, 300);
        test_reply_backpressure();
        test_random_traffic(0, 0, 300);
        test_fill_to_capacity();
        test_full_table();

        // Give a stray extra reply time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (%0d inserts, %0d finds) and %0d replies,",
                 req_seq, insert_count, find_count, reply_count);
        $display("with %0d probe-limit replies after filling all %0d slots; %0d mismatches.",
                 full_reply_count, TABLE_SIZE, error_count);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending_replies.size() != 0) begin
                $display("%0d requests never got a reply", pending_replies.size());
            end
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest legal run.
    initial begin
        #400ms;
        $display("Timeout with %0d replies outstanding", pending_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/dhk_pkg.sv
rtl/core/dhk_if.sv
rtl/core/dhk_hash_unit.sv
rtl/core/double_hash_key_dictionary_unit.sv
dv/tb_double_hash_key_dictionary_unit.sv
